// ----- sv/ges_pkg.sv -----
`default_nettype none
package ges_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLUMNS = 64;

    localparam int CNT_W    = 7;
    localparam int NODE_W   = 12;
    localparam int MODE_W   = 2;
    localparam int DIR_W    = 2;
    localparam int CHOICE_W = 2;
    localparam int STATUS_W = 2;
    localparam int NUM_DIRS = 4;

    localparam int ROW_COUNT_RESET    = 64;
    localparam int COLUMN_COUNT_RESET = 64;
    localparam int CFG_IDX_W          = 1;

    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int REM_W = CNT_W;
    localparam int SUM_W = ROW_W + CNT_W + 1;

    localparam int H_DEPTH   = (MAX_COLUMNS - 1) * MAX_ROWS;
    localparam int V_DEPTH   = MAX_COLUMNS * (MAX_ROWS - 1);
    localparam int H_AW      = $clog2(H_DEPTH);
    localparam int V_AW      = $clog2(V_DEPTH);
    localparam int CLR_DEPTH = (H_DEPTH > V_DEPTH) ? H_DEPTH : V_DEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    localparam int QB        = 3;
    localparam int DIV_STEPS = (NODE_W + QB - 1) / QB;
    localparam int DIV_BITS  = DIV_STEPS * QB;
    localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

    localparam int QDEPTH = 2;
    localparam int Q_AW   = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW_COUNT    = 1'd0,
        REG_COLUMN_COUNT = 1'd1
    } cfg_reg_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_QUERY  = 2'd0,
        MODE_SET    = 2'd1,
        MODE_CLEAR  = 2'd2,
        MODE_CHOOSE = 2'd3
    } mode_t;

    typedef enum logic [DIR_W-1:0] {
        DIR_LEFT  = 2'd0,
        DIR_RIGHT = 2'd1,
        DIR_UP    = 2'd2,
        DIR_DOWN  = 2'd3
    } dir_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CELL = 2'd1,
        ST_OFF_GRID = 2'd2,
        ST_NO_FREE  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_CLEAR,
        B_IDLE,
        B_READ,
        B_EVAL
    } back_state_t;

    typedef struct packed {
        mode_t                 mode;
        dir_t                  dir;
        logic [CHOICE_W-1:0]   choice;
        logic                  cell_ok;
        logic [NUM_DIRS-1:0]   link_ok;
        logic [H_AW-1:0]       h_left;
        logic [H_AW-1:0]       h_right;
        logic [V_AW-1:0]       v_up;
        logic [V_AW-1:0]       v_down;
    } ges_cmd_t;

endpackage
`default_nettype wire

// ----- sv/ges_if.sv -----
`default_nettype none
interface ges_req_if;
    import ges_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [NODE_W-1:0]   node_index;
    logic [DIR_W-1:0]    direction;
    logic [CHOICE_W-1:0] choice;

    modport source (output valid, output mode, output node_index, output direction,
                    output choice, input ready);
    modport sink   (input valid, input mode, input node_index, input direction,
                    input choice, output ready);
endinterface

interface ges_rsp_if;
    import ges_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic                edge_present;
    logic [NUM_DIRS-1:0] free_mask;
    logic [DIR_W-1:0]    chosen_direction;

    modport source (output valid, output status, output edge_present, output free_mask,
                    output chosen_direction, input ready);
    modport sink   (input valid, input status, input edge_present, input free_mask,
                    input chosen_direction, output ready);
endinterface
`default_nettype wire

// ----- sv/ges_ram.sv -----
`default_nettype none
module ges_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

// ----- sv/ges_front.sv -----
`default_nettype none
module ges_front (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [ges_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ges_pkg::CNT_W-1:0]     cfg_data,
    input  wire logic                          clearing,
    ges_req_if.sink                            req,
    output logic                               push,
    output ges_pkg::ges_cmd_t                  push_data,
    input  wire logic                          full
);
    import ges_pkg::*;

    front_state_t          state_reg, state_next;
    logic [CNT_W-1:0]      rows_reg, cols_reg;
    logic [CNT_W-1:0]      rows_use_reg, cols_use_reg;
    mode_t                 mode_reg;
    dir_t                  dir_reg;
    logic [CHOICE_W-1:0]   choice_reg;
    logic [DIV_BITS-1:0]   num_reg;
    logic [NODE_W-1:0]     quot_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [STEP_W-1:0]     step_reg;

    logic [REM_W-1:0]      div_rem;
    logic [NODE_W-1:0]     div_quot;
    logic                  accept;

    logic                  cell_ok;
    logic [NUM_DIRS-1:0]   link_ok;
    logic [SUM_W-1:0]      row_w, col_w, rows_w, cols_w, prod, base_h;
    logic [SUM_W-1:0]      idx_left, idx_right, idx_up, idx_down;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
                                                     input int unsigned maxv);
        logic [CNT_W-1:0] res;
        res = v;
        if (v == '0)
        begin
            res = CNT_W'(1);
        end
        else if (int'(v) > maxv)
        begin
            res = CNT_W'(maxv);
        end
        return res;
    endfunction

    assign accept    = req.valid && req.ready;
    assign req.ready = (state_reg == F_IDLE) && !clearing;

    // restoring division, QB quotient bits per step
    always_comb
    begin
        logic [REM_W-1:0]    r;
        logic [NODE_W-1:0]   q;
        logic [DIV_BITS-1:0] n;
        logic [REM_W:0]      t;
        r = rem_reg;
        q = quot_reg;
        n = num_reg;
        for (int k = 0; k < QB; k++)
        begin
            t = {r, n[DIV_BITS-1]};
            n = n << 1;
            if (t >= {1'b0, cols_use_reg})
            begin
                t = t - {1'b0, cols_use_reg};
                q = {q[NODE_W-2:0], 1'b1};
            end
            else
            begin
                q = {q[NODE_W-2:0], 1'b0};
            end
            r = t[REM_W-1:0];
        end
        div_rem  = r;
        div_quot = q;
    end

    always_comb
    begin
        state_next = state_reg;
        push       = 1'b0;
        case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    state_next = F_DIV;
                end
            end
            F_DIV:
            begin
                if (step_reg == '0)
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                push = 1'b1;
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            rows_reg  <= CNT_W'(ROW_COUNT_RESET);
            cols_reg  <= CNT_W'(COLUMN_COUNT_RESET);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_ROW_COUNT:    rows_reg <= cfg_data;
                    REG_COLUMN_COUNT: cols_reg <= cfg_data;
                    default:          rows_reg <= rows_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg     <= mode_t'(req.mode);
            dir_reg      <= dir_t'(req.direction);
            choice_reg   <= req.choice;
            num_reg      <= DIV_BITS'(req.node_index);
            quot_reg     <= '0;
            rem_reg      <= '0;
            step_reg     <= STEP_W'(DIV_STEPS - 1);
            rows_use_reg <= clamp_count(rows_reg, MAX_ROWS);
            cols_use_reg <= clamp_count(cols_reg, MAX_COLUMNS);
        end
        else if (state_reg == F_DIV)
        begin
            rem_reg  <= div_rem;
            quot_reg <= div_quot;
            num_reg  <= num_reg << QB;
            step_reg <= step_reg - 1'b1;
        end
    end

    // link addresses and in-grid flags of the four neighbors
    always_comb
    begin
        cell_ok    = quot_reg < NODE_W'(rows_use_reg);
        row_w      = SUM_W'(quot_reg[ROW_W-1:0]);
        col_w      = SUM_W'(rem_reg);
        rows_w     = SUM_W'(rows_use_reg);
        cols_w     = SUM_W'(cols_use_reg);
        prod       = row_w * cols_w;
        base_h     = prod - row_w + col_w;
        idx_left   = base_h - SUM_W'(1);
        idx_right  = base_h;
        idx_up     = prod + col_w - cols_w;
        idx_down   = prod + col_w;
        link_ok[0] = cell_ok && (rem_reg != '0);
        link_ok[1] = cell_ok && ((col_w + SUM_W'(1)) < cols_w);
        link_ok[2] = cell_ok && (row_w != '0);
        link_ok[3] = cell_ok && ((row_w + SUM_W'(1)) < rows_w);

        push_data.mode    = mode_reg;
        push_data.dir     = dir_reg;
        push_data.choice  = choice_reg;
        push_data.cell_ok = cell_ok;
        push_data.link_ok = link_ok;
        push_data.h_left  = link_ok[0] ? idx_left[H_AW-1:0]  : '0;
        push_data.h_right = link_ok[1] ? idx_right[H_AW-1:0] : '0;
        push_data.v_up    = link_ok[2] ? idx_up[V_AW-1:0]    : '0;
        push_data.v_down  = link_ok[3] ? idx_down[V_AW-1:0]  : '0;
    end
endmodule
`default_nettype wire

// ----- sv/ges_queue.sv -----
`default_nettype none
module ges_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ges_pkg::ges_cmd_t push_data,
    output logic                   full,
    input  wire logic              pop,
    output ges_pkg::ges_cmd_t      head,
    output logic                   empty
);
    import ges_pkg::*;

    ges_cmd_t            entry_reg [QDEPTH];
    logic [Q_AW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                do_push, do_pop;

    assign full    = count_reg == QCNT_W'(QDEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end
endmodule
`default_nettype wire

// ----- sv/ges_back.sv -----
`default_nettype none
module ges_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ges_pkg::ges_cmd_t head,
    input  wire logic              empty,
    output logic                   pop,
    output logic                   clearing,
    ges_rsp_if.source              rsp
);
    import ges_pkg::*;

    back_state_t          state_reg, state_next;
    logic [CLR_W-1:0]     clr_reg;
    ges_cmd_t             cmd_reg;
    logic                 lft_reg, up_reg;
    logic                 out_valid_reg;
    status_t              status_reg;
    logic                 present_reg;
    logic [NUM_DIRS-1:0]  free_reg;
    dir_t                 chosen_reg;

    logic                 h_we, v_we, h_rdata, v_rdata, wr_val;
    logic [H_AW-1:0]      h_waddr, h_raddr;
    logic [V_AW-1:0]      v_waddr, v_raddr;
    logic                 out_free, eval_fire;

    logic [NUM_DIRS-1:0]  bits, free;
    logic                 present, wr_en, found;
    status_t              status;
    dir_t                 chosen;
    logic [2:0]           cnt;

    ges_ram #(.WIDTH(1), .DEPTH(H_DEPTH)) u_h_ram (
        .clk   (clk),
        .we    (h_we),
        .waddr (h_waddr),
        .wdata (wr_val),
        .raddr (h_raddr),
        .rdata (h_rdata)
    );

    ges_ram #(.WIDTH(1), .DEPTH(V_DEPTH)) u_v_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (v_waddr),
        .wdata (wr_val),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    assign clearing  = state_reg == B_CLEAR;
    assign out_free  = !out_valid_reg || rsp.ready;
    assign eval_fire = (state_reg == B_EVAL) && out_free;

    // decide the result and the write from the four neighbor bits
    always_comb
    begin
        bits    = {v_rdata, up_reg, h_rdata, lft_reg};
        free    = cmd_reg.link_ok & ~bits;
        present = cmd_reg.link_ok[cmd_reg.dir] & bits[cmd_reg.dir];
        status  = ST_OK;
        chosen  = cmd_reg.dir;
        wr_en   = 1'b0;
        wr_val  = 1'b1;
        found   = 1'b0;
        cnt     = '0;
        if (!cmd_reg.cell_ok)
        begin
            status  = ST_BAD_CELL;
            present = 1'b0;
            free    = '0;
        end
        else if (cmd_reg.mode == MODE_CHOOSE)
        begin
            for (int d = 0; d < NUM_DIRS; d++)
            begin
                if (free[d] && !found)
                begin
                    if (cnt == {1'b0, cmd_reg.choice})
                    begin
                        found  = 1'b1;
                        chosen = dir_t'(d);
                    end
                    cnt = cnt + 1'b1;
                end
            end
            wr_en  = found;
            status = found ? ST_OK : ST_NO_FREE;
        end
        else if (!cmd_reg.link_ok[cmd_reg.dir])
        begin
            status = ST_OFF_GRID;
        end
        else if (cmd_reg.mode inside {MODE_SET, MODE_CLEAR})
        begin
            wr_en  = 1'b1;
            wr_val = cmd_reg.mode == MODE_SET;
        end
        if (clearing)
        begin
            wr_val = 1'b0;
        end
    end

    always_comb
    begin
        h_raddr = cmd_reg.h_right;
        v_raddr = cmd_reg.v_down;
        if (state_reg == B_IDLE)
        begin
            h_raddr = head.h_left;
            v_raddr = head.v_up;
        end

        if (clearing)
        begin
            h_we    = clr_reg < CLR_W'(H_DEPTH);
            v_we    = clr_reg < CLR_W'(V_DEPTH);
            h_waddr = clr_reg[H_AW-1:0];
            v_waddr = clr_reg[V_AW-1:0];
        end
        else
        begin
            h_we    = eval_fire && wr_en && (chosen == DIR_LEFT || chosen == DIR_RIGHT);
            v_we    = eval_fire && wr_en && (chosen == DIR_UP || chosen == DIR_DOWN);
            h_waddr = (chosen == DIR_LEFT) ? cmd_reg.h_left : cmd_reg.h_right;
            v_waddr = (chosen == DIR_UP) ? cmd_reg.v_up : cmd_reg.v_down;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        case (state_reg)
            B_CLEAR:
            begin
                if (clr_reg == CLR_W'(CLR_DEPTH - 1))
                begin
                    state_next = B_IDLE;
                end
            end
            B_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    state_next = B_READ;
                end
            end
            B_READ:
            begin
                state_next = B_EVAL;
            end
            B_EVAL:
            begin
                if (out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clearing)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (eval_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg <= head;
        end
        if (state_reg == B_READ)
        begin
            lft_reg <= h_rdata;
            up_reg  <= v_rdata;
        end
        if (eval_fire)
        begin
            status_reg  <= status;
            present_reg <= present;
            free_reg    <= free;
            chosen_reg  <= (status == ST_OK) ? chosen : cmd_reg.dir;
        end
    end

    assign rsp.valid            = out_valid_reg;
    assign rsp.status           = status_reg;
    assign rsp.edge_present     = present_reg;
    assign rsp.free_mask        = free_reg;
    assign rsp.chosen_direction = chosen_reg;
endmodule
`default_nettype wire

// ----- sv/grid_edge_store_core.sv -----
// The front end accepts a new input beat only after the previous one has been pushed
// (accept, 4 divider steps, push; the push waits while the queue is full). The back end
// pops an item, does two link-memory reads, then evaluates and writes, waiting while
// the result is not taken. Reset: row and column counts return to 64; both link memories
// are then cleared by a pass over all 4032 addresses, during which no input beat is accepted.
`default_nettype none
module grid_edge_store_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_write,
    input  wire logic [ges_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ges_pkg::CNT_W-1:0]     cfg_data,
    ges_req_if.sink                            req,
    ges_rsp_if.source                          rsp
);
    import ges_pkg::*;

    ges_cmd_t push_data, head;
    logic     push, full, pop, empty, clearing;

    ges_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .clearing  (clearing),
        .req       (req),
        .push      (push),
        .push_data (push_data),
        .full      (full)
    );

    ges_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    ges_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head),
        .empty    (empty),
        .pop      (pop),
        .clearing (clearing),
        .rsp      (rsp)
    );
endmodule
`default_nettype wire

// ----- sim/ges_checker.sv -----
`timescale 1ns / 100ps
module ges_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [ges_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ges_pkg::CNT_W-1:0]     cfg_data,
    ges_req_if                            req,
    ges_rsp_if                            rsp,
    output int                            failures,
    output int                            pending
);
    import ges_pkg::*;

    typedef struct packed {
        status_t             status;
        logic                present;
        logic [NUM_DIRS-1:0] free;
        dir_t                chosen;
    } link_report_t;

    logic [CNT_W-1:0] row_setting;
    logic [CNT_W-1:0] col_setting;
    bit               horiz_link [H_DEPTH];
    bit               vert_link  [V_DEPTH];
    link_report_t     report_q [$];

    function automatic int clamp_count(logic [CNT_W-1:0] v, int maxv);
        if (v == 0)
            return 1;
        if (int'(v) > maxv)
            return maxv;
        return int'(v);
    endfunction

    function automatic bit link_at(int row, int col, int rows, int cols, dir_t d,
                                   output bit vert, output int idx);
        vert = 1'b0;
        idx  = 0;
        case (d)
            DIR_LEFT:
            begin
                if (col == 0)
                    return 1'b0;
                idx = row * (cols - 1) + col - 1;
            end
            DIR_RIGHT:
            begin
                if (col + 1 >= cols)
                    return 1'b0;
                idx = row * (cols - 1) + col;
            end
            DIR_UP:
            begin
                if (row == 0)
                    return 1'b0;
                vert = 1'b1;
                idx  = (row - 1) * cols + col;
            end
            default:
            begin
                if (row + 1 >= rows)
                    return 1'b0;
                vert = 1'b1;
                idx  = row * cols + col;
            end
        endcase
        return 1'b1;
    endfunction

    function automatic bit link_value(bit vert, int idx);
        return vert ? vert_link[idx] : horiz_link[idx];
    endfunction

    function automatic void write_link(bit vert, int idx, bit val);
        if (vert)
            vert_link[idx] = val;
        else
            horiz_link[idx] = val;
    endfunction

    function automatic link_report_t apply_beat(mode_t mode, logic [NODE_W-1:0] node,
                                                dir_t dir, logic [CHOICE_W-1:0] choice);
        link_report_t r;
        int           rows;
        int           cols;
        int           row;
        int           col;
        int           n;
        int           k;
        int           idx;
        int           i;
        bit           vert;
        bit           v;
        bit           in_grid;
        rows     = clamp_count(row_setting, MAX_ROWS);
        cols     = clamp_count(col_setting, MAX_COLUMNS);
        r.status  = ST_OK;
        r.present = 1'b0;
        r.free    = '0;
        r.chosen  = dir;
        if (int'(node) >= rows * cols)
        begin
            r.status = ST_BAD_CELL;
            return r;
        end
        row = int'(node) / cols;
        col = int'(node) % cols;
        for (k = 0; k < NUM_DIRS; k++)
            if (link_at(row, col, rows, cols, dir_t'(k), v, i) && !link_value(v, i))
                r.free[k] = 1'b1;
        in_grid   = link_at(row, col, rows, cols, dir, vert, idx);
        r.present = in_grid && link_value(vert, idx);
        if (mode == MODE_CHOOSE)
        begin
            r.status = ST_NO_FREE;
            n = 0;
            for (k = 0; k < NUM_DIRS; k++)
            begin
                if (r.free[k])
                begin
                    if (n == int'(choice))
                    begin
                        void'(link_at(row, col, rows, cols, dir_t'(k), v, i));
                        write_link(v, i, 1'b1);
                        r.chosen = dir_t'(k);
                        r.status = ST_OK;
                        break;
                    end
                    n++;
                end
            end
        end
        else if (!in_grid)
            r.status = ST_OFF_GRID;
        else if (mode == MODE_SET)
            write_link(vert, idx, 1'b1);
        else if (mode == MODE_CLEAR)
            write_link(vert, idx, 1'b0);
        return r;
    endfunction

    task automatic check_field(string name, logic [3:0] want, logic [3:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin
        link_report_t want;
        if (!rst_n)
        begin
            row_setting = CNT_W'(ROW_COUNT_RESET);
            col_setting = CNT_W'(COLUMN_COUNT_RESET);
            foreach (horiz_link[j])
                horiz_link[j] = 1'b0;
            foreach (vert_link[j])
                vert_link[j] = 1'b0;
            report_q.delete();
            failures = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_ROW_COUNT)
                    row_setting = cfg_data;
                else
                    col_setting = cfg_data;
            end
            if (rsp.valid && rsp.ready)
            begin
                if (report_q.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, status %0d", $time,
                             rsp.status);
                    failures++;
                end
                else
                begin
                    want = report_q.pop_front();
                    check_field("status", want.status, rsp.status);
                    check_field("edge_present", want.present, rsp.edge_present);
                    check_field("free_mask", want.free, rsp.free_mask);
                    check_field("chosen_direction", want.chosen, rsp.chosen_direction);
                end
            end
            if (req.valid && req.ready)
                report_q.insert(report_q.size(),
                                apply_beat(mode_t'(req.mode), req.node_index,
                                           dir_t'(req.direction), req.choice));
        end
        pending <= report_q.size();
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
module tb_top;
    import ges_pkg::*;

    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int TAIL_CYCLES     = 30;

    logic             clk;
    logic             rst_n;
    logic             cfg_write;
    cfg_reg_t         cfg_index;
    logic [CNT_W-1:0] cfg_data;
    int               fail_count;
    int               pending;
    bit               steady_source;
    bit               steady_sink;
    int               rows_now;
    int               cols_now;

    ges_req_if req_ch ();
    ges_rsp_if rsp_ch ();

    grid_edge_store_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    ges_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .failures  (fail_count),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 70)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    // hold ready low for random stretches
    initial
    begin
        int stall;
        stall = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                stall--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (!steady_sink)
                    stall = pick_gap();
            end
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    task automatic drain();
        req_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending != 0);
    endtask

    task automatic run_item(mode_t m, logic [NODE_W-1:0] node, dir_t d,
                            logic [CHOICE_W-1:0] c);
        int gap;
        gap = steady_source ? 0 : pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.mode       <= m;
        req_ch.node_index <= node;
        req_ch.direction  <= d;
        req_ch.choice     <= c;
        do
            @(posedge clk);
        while (!req_ch.ready);
    endtask

    task automatic set_geometry(logic [CNT_W-1:0] r, logic [CNT_W-1:0] c);
        drain();
        cfg_write <= 1'b1;
        cfg_index <= REG_ROW_COUNT;
        cfg_data  <= r;
        @(posedge clk);
        cfg_index <= REG_COLUMN_COUNT;
        cfg_data  <= c;
        @(posedge clk);
        cfg_write <= 1'b0;
        rows_now = (r == 0) ? 1 : ((int'(r) > MAX_ROWS) ? MAX_ROWS : int'(r));
        cols_now = (c == 0) ? 1 : ((int'(c) > MAX_COLUMNS) ? MAX_COLUMNS : int'(c));
    endtask

    task automatic run_random_item();
        int               pick;
        int               cells;
        mode_t            m;
        logic [NODE_W-1:0] node;
        pick  = $urandom_range(99);
        cells = rows_now * cols_now;
        if (pick < 8)
        begin
            run_item(mode_t'($urandom_range(3)), NODE_W'($urandom), dir_t'($urandom_range(3)),
                     CHOICE_W'($urandom_range(3)));
            return;
        end
        if (pick < 14 && cells < (1 << NODE_W))
            node = NODE_W'($urandom_range((1 << NODE_W) - 1, cells));
        else
            node = NODE_W'($urandom_range(cells - 1, 0));
        pick = $urandom_range(99);
        if (pick < 45)
            m = MODE_CHOOSE;
        else if (pick < 65)
            m = MODE_CLEAR;
        else if (pick < 80)
            m = MODE_SET;
        else
            m = MODE_QUERY;
        run_item(m, node, dir_t'($urandom_range(3)), CHOICE_W'($urandom_range(3)));
    endtask

    initial
    begin
        int p;
        int k;
        rst_n             <= 1'b0;
        cfg_write         <= 1'b0;
        cfg_index         <= REG_ROW_COUNT;
        cfg_data          <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.mode       <= '0;
        req_ch.node_index <= '0;
        req_ch.direction  <= '0;
        req_ch.choice     <= '0;
        steady_source = 1'b0;
        steady_sink   = 1'b0;
        rows_now      = ROW_COUNT_RESET;
        cols_now      = COLUMN_COUNT_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // corners of the full reset grid
        run_item(MODE_QUERY, 12'd0, DIR_LEFT, 2'd0);
        run_item(MODE_SET, 12'd0, DIR_RIGHT, 2'd0);
        run_item(MODE_QUERY, 12'd1, DIR_LEFT, 2'd0);
        run_item(MODE_CHOOSE, 12'd0, DIR_UP, 2'd0);
        run_item(MODE_CHOOSE, 12'd0, DIR_LEFT, 2'd1);
        run_item(MODE_CLEAR, 12'd1, DIR_LEFT, 2'd0);
        run_item(MODE_SET, 12'd4095, DIR_DOWN, 2'd0);
        run_item(MODE_QUERY, 12'd4095, DIR_RIGHT, 2'd0);
        run_item(MODE_CHOOSE, 12'd4095, DIR_UP, 2'd3);
        run_item(MODE_CHOOSE, 12'd4095, DIR_DOWN, 2'd1);
        run_item(MODE_SET, 12'd4095, DIR_LEFT, 2'd0);
        run_item(MODE_CLEAR, 12'd4095, DIR_UP, 2'd0);

        set_geometry(7'd3, 7'd3);
        run_item(MODE_QUERY, 12'd9, DIR_LEFT, 2'd0);
        run_item(MODE_SET, 12'd4095, DIR_RIGHT, 2'd0);
        run_item(MODE_CHOOSE, 12'd4, DIR_LEFT, 2'd3);
        run_item(MODE_CHOOSE, 12'd4, DIR_LEFT, 2'd3);
        run_item(MODE_QUERY, 12'd7, DIR_UP, 2'd0);
        run_item(MODE_CLEAR, 12'd7, DIR_UP, 2'd0);

        set_geometry(7'd0, 7'd127);
        run_item(MODE_QUERY, 12'd0, DIR_UP, 2'd0);
        run_item(MODE_CHOOSE, 12'd63, DIR_RIGHT, 2'd0);
        run_item(MODE_QUERY, 12'd64, DIR_LEFT, 2'd0);

        set_geometry(7'd127, 7'd0);
        run_item(MODE_CHOOSE, 12'd0, DIR_LEFT, 2'd0);
        run_item(MODE_SET, 12'd63, DIR_DOWN, 2'd0);
        run_item(MODE_QUERY, 12'd63, DIR_RIGHT, 2'd0);

        for (p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       set_geometry(7'd0, 7'd0);
                1:       set_geometry(7'd127, 7'd127);
                2:       set_geometry(7'd1, 7'd64);
                3:       set_geometry(7'd64, 7'd1);
                4:       set_geometry(7'd2, 7'd2);
                5:       set_geometry(7'd100, 7'd3);
                6:       set_geometry(7'd64, 7'd64);
                default: set_geometry(CNT_W'($urandom_range(8, 2)),
                                      CNT_W'($urandom_range(8, 2)));
            endcase
            steady_source = ($urandom_range(3) == 0);
            steady_sink   = ($urandom_range(3) == 0);
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if ($urandom_range(199) == 0)
                    drain();
                run_random_item();
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/ges_pkg.sv
sv/ges_if.sv
sv/ges_ram.sv
sv/ges_front.sv
sv/ges_queue.sv
sv/ges_back.sv
sv/grid_edge_store_core.sv
sim/ges_checker.sv
sim/tb_top.sv
